// ----- design/slx_pkg.sv -----
// Shared types, constants and helper functions for the script token lexer.
// No dependencies; compiled first.
`default_nettype none

package slx_pkg;

    localparam int POS_BITS      = 24;
    localparam int LEN_BITS      = 24;
    localparam int KEYWORD_CHARS = 6;
    localparam int MAX_RESULTS   = 3;

    typedef logic [POS_BITS-1:0]           pos_t;
    typedef logic [LEN_BITS-1:0]           len_t;
    typedef logic [KEYWORD_CHARS-1:0][7:0] word_buf_t;

    localparam len_t LEN_MAX = '1;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'd0,
        MODE_PEND  = 4'd1,
        MODE_STR   = 4'd2,
        MODE_BLOCK = 4'd3,
        MODE_LINE  = 4'd4,
        MODE_NUM   = 4'd5,
        MODE_WORD  = 4'd6
    } scan_mode_t;

    typedef enum logic [5:0] {
        TK_PLUS, TK_MINUS, TK_STAR, TK_SLASH, TK_DOUBLE_PLUS, TK_DOUBLE_MINUS,
        TK_DOUBLE_STAR, TK_DOUBLE_SLASH, TK_ASSIGN, TK_EQUAL, TK_NOT, TK_NOT_EQUAL,
        TK_GREATER_THAN, TK_GREATER_EQUAL, TK_LESS_THAN, TK_LESS_EQUAL,
        TK_PERCENTAGE, TK_OPEN_PAREN, TK_CLOSE_PAREN, TK_OPEN_BRACKET,
        TK_CLOSE_BRACKET, TK_OPEN_CURLY, TK_CLOSE_CURLY, TK_DOT, TK_DOUBLE_DOT,
        TK_COMMA, TK_STRING, TK_NUMBER, TK_NAME, TK_IF, TK_ELSE, TK_TRUE,
        TK_FALSE, TK_NIL, TK_FOR, TK_IN, TK_WHILE, TK_DO, TK_FUNC, TK_RETURN,
        TK_END
    } token_kind_t;

    typedef struct packed {
        scan_mode_t mode;
        logic [7:0] pend_char;
        pos_t       tok_start;
        pos_t       byte_pos;
        word_buf_t  word_buf;
        len_t       word_len;
        logic       star_seen;
    } lex_state_t;

    localparam lex_state_t LEX_RESET = '{
        mode:      MODE_IDLE,
        pend_char: 8'd0,
        tok_start: '0,
        byte_pos:  '0,
        word_buf:  '0,
        word_len:  '0,
        star_seen: 1'b0
    };

    typedef struct packed {
        token_kind_t kind;
        logic [23:0] start;
        logic [23:0] length;
        logic        last;
    } res_t;

    typedef struct packed {
        res_t [MAX_RESULTS-1:0] item;
        logic [1:0]             count;
    } res_bundle_t;

    function automatic pos_t pos_add(input pos_t p, input logic [1:0] k);
        logic [POS_BITS:0] s;
        s = {1'b0, p} + {{(POS_BITS-1){1'b0}}, k};
        return s[POS_BITS] ? pos_t'('1) : s[POS_BITS-1:0];
    endfunction

    function automatic logic [23:0] to_field(input pos_t p);
        logic [31:0] w;
        w = 32'(p);
        return (w > 32'(LEN_MAX)) ? LEN_MAX : w[23:0];
    endfunction

    function automatic len_t len_inc(input len_t n);
        return (n == LEN_MAX) ? n : n + len_t'(1);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    endfunction

    function automatic logic is_namech(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || (b == "_");
    endfunction

    function automatic logic is_pend_op(input logic [7:0] b);
        return (b == "+") || (b == "-") || (b == "*") || (b == "/") || (b == "=") ||
               (b == "!") || (b == ">") || (b == "<") || (b == ".");
    endfunction

    function automatic token_kind_t single_kind(input logic [7:0] c);
        token_kind_t k;
        unique case (c)
            "+":     k = TK_PLUS;
            "-":     k = TK_MINUS;
            "*":     k = TK_STAR;
            "/":     k = TK_SLASH;
            "=":     k = TK_ASSIGN;
            "!":     k = TK_NOT;
            ">":     k = TK_GREATER_THAN;
            "<":     k = TK_LESS_THAN;
            default: k = TK_DOT;
        endcase
        return k;
    endfunction

    function automatic logic pair_ok(input logic [7:0] c, input logic [7:0] b);
        logic ok;
        unique case (c)
            "+", "-", "*", "/", ".": ok = (b == c);
            "=", "!", ">", "<":      ok = (b == "=");
            default:                 ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic token_kind_t pair_kind(input logic [7:0] c);
        token_kind_t k;
        unique case (c)
            "+":     k = TK_DOUBLE_PLUS;
            "-":     k = TK_DOUBLE_MINUS;
            "*":     k = TK_DOUBLE_STAR;
            "/":     k = TK_DOUBLE_SLASH;
            "=":     k = TK_EQUAL;
            "!":     k = TK_NOT_EQUAL;
            ">":     k = TK_GREATER_EQUAL;
            "<":     k = TK_LESS_EQUAL;
            default: k = TK_DOUBLE_DOT;
        endcase
        return k;
    endfunction

    // single-byte tokens decided at once
    function automatic logic is_single(input logic [7:0] b);
        return (b == "%") || (b == "(") || (b == ")") || (b == "[") || (b == "]") ||
               (b == "{") || (b == "}") || (b == ",");
    endfunction

    function automatic token_kind_t single_now_kind(input logic [7:0] b);
        token_kind_t k;
        unique case (b)
            "%":     k = TK_PERCENTAGE;
            "(":     k = TK_OPEN_PAREN;
            ")":     k = TK_CLOSE_PAREN;
            "[":     k = TK_OPEN_BRACKET;
            "]":     k = TK_CLOSE_BRACKET;
            "{":     k = TK_OPEN_CURLY;
            "}":     k = TK_CLOSE_CURLY;
            default: k = TK_COMMA;
        endcase
        return k;
    endfunction

    function automatic token_kind_t word_kind(input word_buf_t w, input len_t n);
        token_kind_t k;
        k = TK_NAME;
        if (n == len_t'(2) && {w[0], w[1]} == "if")
            k = TK_IF;
        else if (n == len_t'(2) && {w[0], w[1]} == "in")
            k = TK_IN;
        else if (n == len_t'(2) && {w[0], w[1]} == "do")
            k = TK_DO;
        else if (n == len_t'(3) && {w[0], w[1], w[2]} == "nil")
            k = TK_NIL;
        else if (n == len_t'(3) && {w[0], w[1], w[2]} == "for")
            k = TK_FOR;
        else if (n == len_t'(4) && {w[0], w[1], w[2], w[3]} == "else")
            k = TK_ELSE;
        else if (n == len_t'(4) && {w[0], w[1], w[2], w[3]} == "true")
            k = TK_TRUE;
        else if (n == len_t'(4) && {w[0], w[1], w[2], w[3]} == "func")
            k = TK_FUNC;
        else if (n == len_t'(5) && {w[0], w[1], w[2], w[3], w[4]} == "false")
            k = TK_FALSE;
        else if (n == len_t'(5) && {w[0], w[1], w[2], w[3], w[4]} == "while")
            k = TK_WHILE;
        else if (n == len_t'(6) && {w[0], w[1], w[2], w[3], w[4], w[5]} == "return")
            k = TK_RETURN;
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- design/slx_ifs.sv -----
// Valid/ready channel interfaces for the script token lexer.
// Depends on nothing; payload widths follow the field list.
`default_nettype none

interface slx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       byte_present;
    logic       end_of_source;

    modport source (output valid, source_byte, byte_present, end_of_source, input ready);
    modport sink   (input valid, source_byte, byte_present, end_of_source, output ready);
endinterface

interface slx_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [23:0] start_position;
    logic [23:0] token_length;
    logic        last_token;

    modport source (output valid, token_kind, start_position, token_length, last_token,
                    input ready);
    modport sink   (input valid, token_kind, start_position, token_length, last_token,
                    output ready);
endinterface

`default_nettype wire

// ----- design/slx_step.sv -----
// Next-state and token logic for one input transaction of the lexer.
// Depends on slx_pkg.
`default_nettype none

module slx_step (
    input  slx_pkg::lex_state_t  state,
    input  logic [7:0]           source_byte,
    input  logic                 byte_present,
    input  logic                 end_of_source,
    output slx_pkg::lex_state_t  state_next,
    output slx_pkg::res_bundle_t results
);
    import slx_pkg::*;

    lex_state_t ns;
    res_t       cand [4];
    logic [3:0] cand_v;
    logic       do_disp;
    pos_t       p;
    logic [1:0] extra;
    logic [1:0] n;

    always_comb
    begin
        ns      = state;
        do_disp = 1'b0;
        p       = state.byte_pos;
        extra   = 2'd1;
        cand_v  = '0;
        for (int i = 0; i < 4; i++)
        begin
            cand[i] = '{kind: TK_END, start: 24'd0, length: 24'd0, last: 1'b0};
        end

        // slot 0: token closed by this byte, slot 1: token it starts and ends
        if (byte_present)
        begin
            ns.byte_pos = pos_add(state.byte_pos, 2'd1);
            unique case (state.mode)
                MODE_PEND:
                begin
                    if (state.pend_char == "/" && source_byte == "*")
                    begin
                        ns.mode      = MODE_BLOCK;
                        ns.star_seen = 1'b1;
                    end
                    else if (pair_ok(state.pend_char, source_byte))
                    begin
                        ns.mode   = MODE_IDLE;
                        cand_v[0] = 1'b1;
                        cand[0]   = '{kind: pair_kind(state.pend_char),
                                      start: to_field(state.tok_start),
                                      length: 24'd2, last: 1'b0};
                    end
                    else
                    begin
                        ns.mode   = MODE_IDLE;
                        do_disp   = 1'b1;
                        cand_v[0] = 1'b1;
                        cand[0]   = '{kind: single_kind(state.pend_char),
                                      start: to_field(state.tok_start),
                                      length: 24'd1, last: 1'b0};
                    end
                end
                MODE_STR:
                begin
                    if (source_byte == "\"")
                    begin
                        ns.mode   = MODE_IDLE;
                        cand_v[0] = 1'b1;
                        cand[0]   = '{kind: TK_STRING, start: to_field(state.tok_start),
                                      length: len_inc(state.word_len), last: 1'b0};
                    end
                    else
                    begin
                        ns.word_len = len_inc(state.word_len);
                    end
                end
                MODE_BLOCK:
                begin
                    if (state.star_seen && source_byte == "/")
                    begin
                        ns.mode      = MODE_IDLE;
                        ns.star_seen = 1'b0;
                    end
                    else
                    begin
                        ns.star_seen = (source_byte == "*");
                    end
                end
                MODE_LINE:
                begin
                    if (source_byte == "\n")
                        ns.mode = MODE_IDLE;
                end
                MODE_NUM:
                begin
                    if (is_digit(source_byte))
                    begin
                        ns.word_len = len_inc(state.word_len);
                    end
                    else
                    begin
                        ns.mode   = MODE_IDLE;
                        do_disp   = 1'b1;
                        cand_v[0] = 1'b1;
                        cand[0]   = '{kind: TK_NUMBER, start: to_field(state.tok_start),
                                      length: state.word_len, last: 1'b0};
                    end
                end
                MODE_WORD:
                begin
                    if (is_namech(source_byte))
                    begin
                        for (int i = 0; i < KEYWORD_CHARS; i++)
                        begin
                            if (state.word_len == len_t'(i))
                                ns.word_buf[i] = source_byte;
                        end
                        ns.word_len = len_inc(state.word_len);
                    end
                    else
                    begin
                        ns.mode   = MODE_IDLE;
                        do_disp   = 1'b1;
                        cand_v[0] = 1'b1;
                        cand[0]   = '{kind: word_kind(state.word_buf, state.word_len),
                                      start: to_field(state.tok_start),
                                      length: state.word_len, last: 1'b0};
                    end
                end
                default:
                begin
                    ns.mode = MODE_IDLE;
                    do_disp = 1'b1;
                end
            endcase

            if (do_disp)
            begin
                ns.tok_start = p;
                ns.word_len  = len_t'(1);
                if (is_pend_op(source_byte))
                begin
                    ns.pend_char = source_byte;
                    ns.mode      = MODE_PEND;
                end
                else if (is_single(source_byte))
                begin
                    cand_v[1] = 1'b1;
                    cand[1]   = '{kind: single_now_kind(source_byte), start: to_field(p),
                                  length: 24'd1, last: 1'b0};
                end
                else if (source_byte == "#")
                    ns.mode = MODE_LINE;
                else if (source_byte == "\"")
                    ns.mode = MODE_STR;
                else if (is_digit(source_byte))
                    ns.mode = MODE_NUM;
                else if (is_alpha(source_byte))
                begin
                    ns.word_buf    = '0;
                    ns.word_buf[0] = source_byte;
                    ns.mode        = MODE_WORD;
                end
            end
        end

        // slot 2: token left open at end of source, slot 3: END
        if (end_of_source)
        begin
            unique case (ns.mode)
                MODE_PEND:
                begin
                    cand_v[2] = 1'b1;
                    cand[2]   = '{kind: single_kind(ns.pend_char), start: to_field(ns.tok_start),
                                  length: 24'd1, last: 1'b0};
                end
                MODE_STR:
                begin
                    extra     = 2'd2;
                    cand_v[2] = 1'b1;
                    cand[2]   = '{kind: TK_STRING, start: to_field(ns.tok_start),
                                  length: ns.word_len, last: 1'b0};
                end
                MODE_BLOCK:
                    extra = 2'd2;
                MODE_NUM:
                begin
                    cand_v[2] = 1'b1;
                    cand[2]   = '{kind: TK_NUMBER, start: to_field(ns.tok_start),
                                  length: ns.word_len, last: 1'b0};
                end
                MODE_WORD:
                begin
                    cand_v[2] = 1'b1;
                    cand[2]   = '{kind: word_kind(ns.word_buf, ns.word_len),
                                  start: to_field(ns.tok_start),
                                  length: ns.word_len, last: 1'b0};
                end
                default:
                    extra = 2'd1;
            endcase
            cand_v[3] = 1'b1;
            cand[3]   = '{kind: TK_END, start: to_field(pos_add(ns.byte_pos, extra)),
                          length: 24'd0, last: 1'b1};
            ns = LEX_RESET;
        end

        // pack in order; anything beyond three tokens is dropped
        results = '0;
        n       = 2'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (cand_v[i] && n != 2'd3)
            begin
                results.item[n] = cand[i];
                n               = n + 2'd1;
            end
        end
        results.count = n;
        state_next    = ns;
    end

endmodule

`default_nettype wire

// ----- design/slx_res_buf.sv -----
// Three-entry result buffer that drains tokens one transaction at a time.
// Depends on slx_pkg and slx_out_if.
`default_nettype none

module slx_res_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  slx_pkg::res_bundle_t results,
    output logic                 can_load,
    slx_out_if.source            out_ch
);
    import slx_pkg::*;

    res_t       slot_reg [MAX_RESULTS];
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       take;

    assign take     = out_ch.valid && out_ch.ready;
    assign can_load = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ch.ready);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
            cnt_next = results.count;
        else if (take)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                slot_reg[i] <= results.item[i];
            end
        end
        else if (take)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                slot_reg[i] <= slot_reg[i+1];
            end
        end
    end

    assign out_ch.valid          = (cnt_reg != 2'd0);
    assign out_ch.token_kind     = slot_reg[0].kind;
    assign out_ch.start_position = slot_reg[0].start;
    assign out_ch.token_length   = slot_reg[0].length;
    assign out_ch.last_token     = slot_reg[0].last;

endmodule

`default_nettype wire

// ----- design/script_token_lexer.sv -----
// Script token lexer: one source byte in per transaction, tokens out as kind/start/length.
// Depends on slx_pkg, slx_ifs, slx_step and slx_res_buf.
//
// The lexer takes one input transaction per clock while the buffer can load. Each
// accepted transaction updates the registered scan state and yields zero to three
// tokens, which are held in a three-entry result buffer and leave one per output
// transaction, first one the cycle after the input was taken. A new input is taken
// whenever the buffer is empty or its last token is leaving in the same cycle, so
// input runs at one byte per clock while items yield at most one token each and the
// output is not stalled. The END token closes a source (last_token high) and returns the
// lexer to its reset state; no start-up pass is needed after reset.
`default_nettype none

module script_token_lexer (
    input  logic      clk,
    input  logic      rst_n,
    slx_in_if.sink    in_ch,
    slx_out_if.source out_ch
);
    import slx_pkg::*;

    lex_state_t  state_reg;
    lex_state_t  state_next;
    res_bundle_t results;
    logic        can_load;
    logic        accept;

    assign in_ch.ready = can_load;
    assign accept      = in_ch.valid && can_load;

    slx_step u_step (
        .state         (state_reg),
        .source_byte   (in_ch.source_byte),
        .byte_present  (in_ch.byte_present),
        .end_of_source (in_ch.end_of_source),
        .state_next    (state_next),
        .results       (results)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= LEX_RESET;
        else if (accept)
            state_reg <= state_next;
    end

    slx_res_buf u_res_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .results  (results),
        .can_load (can_load),
        .out_ch   (out_ch)
    );

endmodule

`default_nettype wire

// ----- design/slx_checker.sv -----
// Port-level assertions for script_token_lexer, attached by bind.
// Depends on slx_pkg.
`default_nettype none

module slx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [5:0]  token_kind,
    input logic [23:0] start_position,
    input logic [23:0] token_length,
    input logic        last_token
);
    import slx_pkg::*;

    // stalled token holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind) &&
        $stable(start_position) && $stable(token_length) && $stable(last_token))
        else $error("output token changed while stalled");

    // input only back-pressures while tokens are pending
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no token pending");

    a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_token |-> token_kind == 6'(TK_END) && token_length == 24'd0)
        else $error("last token is not a zero-length END");

    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_length == 24'd0 |-> last_token)
        else $error("zero-length token other than END");

endmodule

bind script_token_lexer slx_checker u_slx_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .token_kind     (out_ch.token_kind),
    .start_position (out_ch.start_position),
    .token_length   (out_ch.token_length),
    .last_token     (out_ch.last_token)
);

`default_nettype wire
